// ===== rtl/aesd_pkg.sv =====
// ----------------------------------------------------------------------------
// aesd_pkg - shared types and GF(2^8) helpers for the AES-128 decrypt unit
// Byte k of a 128-bit block sits in bits [127-8k -: 8].
// ----------------------------------------------------------------------------
package aesd_pkg;

	typedef logic [127:0] block_t;
	typedef logic [7:0] sbox_t [256];

	localparam int NumRounds = 10;

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] p;
		acc = 8'h00;
		p = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc = acc ^ p;
			p = xtime(p);
		end
		return acc;
	endfunction

	function automatic logic [7:0] gf_inv(input logic [7:0] x);
		logic [7:0] r;
		logic [7:0] p;
		logic [7:0] e;
		r = 8'h01;
		p = x;
		e = 8'd254;
		for (int i = 0; i < 8; i++) begin
			if (e[i]) r = gf_mul(r, p);
			p = gf_mul(p, p);
		end
		return r;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
		return (x << n) | (x >> (8 - n));
	endfunction

	// Tables are built at elaboration and read as plain lookups.
	function automatic sbox_t make_fwd_sbox();
		sbox_t t;
		logic [7:0] b;
		for (int i = 0; i < 256; i++) begin
			b = gf_inv(8'(i));
			t[i] = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
		end
		return t;
	endfunction

	function automatic sbox_t make_inv_sub_tab();
		sbox_t t;
		logic [7:0] y;
		for (int i = 0; i < 256; i++) begin
			y = 8'(i);
			t[i] = gf_inv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05);
		end
		return t;
	endfunction

	localparam sbox_t FWD_SBOX = make_fwd_sbox();
	localparam sbox_t INV_SUB_TAB = make_inv_sub_tab();

	function automatic logic [7:0] get_byte(input block_t s, input int k);
		return s[127 - 8 * k -: 8];
	endfunction

	// InvShiftRows followed by InvSubBytes
	function automatic block_t inv_rows_sub(input block_t s);
		block_t t;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				t[127 - 8 * (c * 4 + r) -: 8] =
					INV_SUB_TAB[get_byte(s, ((c - r + 4) % 4) * 4 + r)];
			end
		end
		return t;
	endfunction

	function automatic block_t inv_mix(input block_t s);
		block_t t;
		logic [7:0] a, b, c2, d;
		for (int c = 0; c < 4; c++) begin
			a = get_byte(s, c * 4);
			b = get_byte(s, c * 4 + 1);
			c2 = get_byte(s, c * 4 + 2);
			d = get_byte(s, c * 4 + 3);
			t[127 - 8 * (c * 4) -: 8] = gf_mul(a, 8'h0e) ^ gf_mul(b, 8'h0b)
				^ gf_mul(c2, 8'h0d) ^ gf_mul(d, 8'h09);
			t[127 - 8 * (c * 4 + 1) -: 8] = gf_mul(a, 8'h09) ^ gf_mul(b, 8'h0e)
				^ gf_mul(c2, 8'h0b) ^ gf_mul(d, 8'h0d);
			t[127 - 8 * (c * 4 + 2) -: 8] = gf_mul(a, 8'h0d) ^ gf_mul(b, 8'h09)
				^ gf_mul(c2, 8'h0e) ^ gf_mul(d, 8'h0b);
			t[127 - 8 * (c * 4 + 3) -: 8] = gf_mul(a, 8'h0b) ^ gf_mul(b, 8'h0d)
				^ gf_mul(c2, 8'h09) ^ gf_mul(d, 8'h0e);
		end
		return t;
	endfunction

	// One step of the AES-128 key schedule
	function automatic block_t next_round_key(input block_t w, input logic [7:0] rc);
		logic [31:0] t, n0, n1, n2, n3;
		t = {FWD_SBOX[w[23:16]] ^ rc, FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]], FWD_SBOX[w[31:24]]};
		n0 = w[127:96] ^ t;
		n1 = w[95:64] ^ n0;
		n2 = w[63:32] ^ n1;
		n3 = w[31:0] ^ n2;
		return {n0, n1, n2, n3};
	endfunction

endpackage

// ===== rtl/aesd_cipher_if.sv =====
// ----------------------------------------------------------------------------
// aesd_cipher_if - ciphertext word channel
// valid/ready handshake carrying one 128-bit ciphertext block.
// ----------------------------------------------------------------------------
interface aesd_cipher_if;
	logic        valid;
	logic        ready;
	logic [63:0] cipher_hi;
	logic [63:0] cipher_lo;

	modport source (output valid, output cipher_hi, output cipher_lo, input ready);
	modport sink (input valid, input cipher_hi, input cipher_lo, output ready);
endinterface

// ===== rtl/aesd_plain_if.sv =====
// ----------------------------------------------------------------------------
// aesd_plain_if - plaintext word channel
// valid/ready handshake carrying one 128-bit plaintext block.
// ----------------------------------------------------------------------------
interface aesd_plain_if;
	logic        valid;
	logic        ready;
	logic [63:0] plain_hi;
	logic [63:0] plain_lo;

	modport source (output valid, output plain_hi, output plain_lo, input ready);
	modport sink (input valid, input plain_hi, input plain_lo, output ready);
endinterface

// ===== rtl/aesd_round_cell.sv =====
// ----------------------------------------------------------------------------
// aesd_round_cell - one inverse round
// InvShiftRows, InvSubBytes, AddRoundKey and (unless last) InvMixColumns.
// ----------------------------------------------------------------------------
module aesd_round_cell #(
	parameter bit LAST = 1'b0
) (
	input  logic            clk,
	input  logic            en,
	input  aesd_pkg::block_t state_in,
	input  aesd_pkg::block_t rkey,
	output aesd_pkg::block_t state_out
);
	import aesd_pkg::*;

	block_t added;
	block_t state_q;

	assign added = inv_rows_sub(state_in) ^ rkey;

	always_ff @(posedge clk) begin
		if (en) begin
			state_q <= LAST ? added : inv_mix(added);
		end
	end

	assign state_out = state_q;
endmodule

// ===== rtl/aesd_key_sched.sv =====
// ----------------------------------------------------------------------------
// aesd_key_sched - round key expansion
// Steps the key schedule once per cycle after a start, holding all 11 keys.
// ----------------------------------------------------------------------------
module aesd_key_sched (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  aesd_pkg::block_t key,
	output logic             busy,
	output aesd_pkg::block_t rkeys [aesd_pkg::NumRounds + 1]
);
	import aesd_pkg::*;

	block_t     rk_q [NumRounds + 1];
	block_t     cur_q;
	block_t     nxt;
	logic [7:0] rc_q;
	logic [3:0] cnt_q;
	logic       busy_q;

	assign nxt = next_round_key(cur_q, rc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd1;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'(NumRounds)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q    <= key;
			rk_q[0]  <= key;
			rc_q     <= 8'h01;
		end else if (busy_q) begin
			cur_q       <= nxt;
			rk_q[cnt_q] <= nxt;
			rc_q        <= xtime(rc_q);
		end
	end

	assign busy = busy_q;
	assign rkeys = rk_q;
endmodule

// ===== rtl/aes128_block_decrypt_unit.sv =====
// ----------------------------------------------------------------------------
// aes128_block_decrypt_unit - AES-128 inverse cipher, one block per cycle
// unless stalled; ten chained round cells behind an initial AddRoundKey stage.
// ----------------------------------------------------------------------------
//  channel   dir  payload                    handshake
//  cin       in   cipher_hi, cipher_lo       valid/ready
//  pout      out  plain_hi, plain_lo         valid/ready
//  apb       in   key_hi @0x0, key_lo @0x8   psel/penable/pwrite, pready=1
//
//  Throughput: one word per cycle unless the chain holds or the key schedule
//  runs. Pipeline: input stage plus ten round cells, each a register.
//  The whole chain advances together; it holds while the last stage has a
//  word that the sink does not take.
//  After reset and after each key write the schedule runs (one load, ten
//  expansion steps) and cin.ready stays low meanwhile.
// ----------------------------------------------------------------------------
module aes128_block_decrypt_unit (
	input  logic        clk,
	input  logic        arst_n,
	aesd_cipher_if.sink cin,
	aesd_plain_if.source pout,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import aesd_pkg::*;

	logic [63:0] key_hi_q;
	logic [63:0] key_lo_q;
	logic        start_q;
	logic        ks_busy;
	logic        adv;
	logic        wr;
	block_t      rks [NumRounds + 1];
	block_t      stage [NumRounds + 1];
	logic [NumRounds:0] vld_q;
	block_t      s0_q;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign prdata = paddr[3] ? key_lo_q : key_hi_q;

	// key registers; a write (or reset) kicks the schedule next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			start_q  <= 1'b1;
		end else begin
			start_q <= wr;
			if (wr) begin
				if (paddr[3]) key_lo_q <= pwdata;
				else key_hi_q <= pwdata;
			end
		end
	end

	aesd_key_sched u_ks (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start_q),
		.key        ({key_hi_q, key_lo_q}),
		.busy       (ks_busy),
		.rkeys      (rks)
	);

	// chain moves unless the output holds a word not yet taken
	assign adv = !vld_q[NumRounds] || pout.ready;
	assign cin.ready = adv && !ks_busy && !start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NumRounds-1:0], cin.valid && cin.ready};
		end
	end

	// first stage: whitening with the last round key
	always_ff @(posedge clk) begin
		if (adv) begin
			s0_q <= {cin.cipher_hi, cin.cipher_lo} ^ rks[NumRounds];
		end
	end

	assign stage[0] = s0_q;

	for (genvar i = 1; i <= NumRounds; i++) begin : g_round
		aesd_round_cell #(
			.LAST (i == NumRounds)
		) u_cell (
			.clk       (clk),
			.en        (adv),
			.state_in  (stage[i-1]),
			.rkey      (rks[NumRounds - i]),
			.state_out (stage[i])
		);
	end

	assign pout.valid    = vld_q[NumRounds];
	assign pout.plain_hi = stage[NumRounds][127:64];
	assign pout.plain_lo = stage[NumRounds][63:0];
endmodule
